@@ rtl/bfpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfpw_pkg;

	localparam int CoordW    = 13;
	localparam int ScreenW   = 12;
	localparam int PitchW    = 14;
	localparam int PbW       = 3;
	localparam int LayoutW   = 27;
	localparam int KbW       = 7;
	localparam int ColourW   = 8;
	localparam int BankW     = 16;
	localparam int OffsetW   = 16;
	localparam int PixelW    = 32;
	localparam int KbShift   = 10;
	localparam int AddrW     = 26;
	localparam int BankGW    = BankW + KbW;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = LayoutW;
	localparam int DivSteps  = BankW;
	localparam int DivCntW   = $clog2(DivSteps);
	localparam int PosW      = 5;
	localparam int SizeW     = 4;

	localparam logic [ScreenW-1:0] WidthRst  = ScreenW'(640);
	localparam logic [ScreenW-1:0] HeightRst = ScreenW'(480);
	localparam logic [PitchW-1:0]  PitchRst  = PitchW'(1280);
	localparam logic [PbW-1:0]     PbRst     = PbW'(2);
	localparam logic [LayoutW-1:0] LayoutRst = '0;
	localparam logic [KbW-1:0]     KbRst     = KbW'(64);
	localparam logic [KbW-1:0]     KbMax     = KbW'(64);
	localparam logic [PbW-1:0]     PbMax     = PbW'(4);

	typedef enum logic [CfgIdxW-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_PITCH  = 3'd2,
		REG_PBYTES = 3'd3,
		REG_LAYOUT = 3'd4,
		REG_GRAN   = 3'd5,
		REG_WINDOW = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADDR,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic addr;
		logic div_start;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic onscreen;
		logic in_window;
		logic out_free;
	} status_t;

	function automatic logic [KbW-1:0] clamp_kb(input logic [KbW-1:0] v);
		logic [KbW-1:0] r;
		r = v;
		if (v == '0)
			r = KbW'(1);
		else if (v > KbMax)
			r = KbMax;
		return r;
	endfunction

	function automatic logic [PbW-1:0] clamp_pb(input logic [PbW-1:0] v);
		logic [PbW-1:0] r;
		r = v;
		if (v == '0)
			r = PbW'(1);
		else if (v > PbMax)
			r = PbMax;
		return r;
	endfunction

	// keep the top 'size' bits of the colour, then move it to its field position
	function automatic logic [PixelW-1:0] place_colour(input logic [ColourW-1:0] c,
			input logic [SizeW-1:0] size, input logic [PosW-1:0] pos);
		logic [ColourW-1:0] v;
		logic [SizeW-1:0] sh;
		v = c;
		sh = SizeW'(ColourW) - size;
		if (size < SizeW'(ColourW))
			v = c >> sh;
		return PixelW'(v) << pos;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bfpw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfpw_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  bfpw_pkg::status_t status,
	output bfpw_pkg::cmd_t   cmd
);
	import bfpw_pkg::*;

	state_t state_q, state_d;
	logic [DivCntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + DivCntW'(1);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (status.onscreen && !status.in_window) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DivCntW'(DivSteps - 1))
					state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bfpw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfpw_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_write,
	input  wire  [bfpw_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire  [bfpw_pkg::CfgDataW-1:0]      cfg_data,
	input  wire  [bfpw_pkg::CoordW-1:0]        column,
	input  wire  [bfpw_pkg::CoordW-1:0]        row,
	input  wire  [bfpw_pkg::ColourW-1:0]       red,
	input  wire  [bfpw_pkg::ColourW-1:0]       green,
	input  wire  [bfpw_pkg::ColourW-1:0]       blue,
	input  wire                                out_stall,
	output logic                               out_valid,
	output logic                               write_enable,
	output logic                               bank_changed,
	output logic [bfpw_pkg::BankW-1:0]         bank_number,
	output logic [bfpw_pkg::OffsetW-1:0]       window_offset,
	output logic [bfpw_pkg::PixelW-1:0]        pixel_value,
	output logic [bfpw_pkg::PbW-1:0]           byte_count,
	input  bfpw_pkg::cmd_t                     cmd,
	output bfpw_pkg::status_t                  status
);
	import bfpw_pkg::*;

	// configuration
	logic [ScreenW-1:0] width_q, height_q;
	logic [PitchW-1:0]  pitch_q;
	logic [PbW-1:0]     pb_raw_q;
	logic [LayoutW-1:0] layout_q;
	logic [KbW-1:0]     gran_raw_q, win_raw_q;

	logic [PbW-1:0] pb;
	logic [KbW-1:0] gran, win;

	// item registers
	logic [CoordW-1:0]  col_q, row_q;
	logic [ColourW-1:0] red_q, green_q, blue_q;
	logic               onscreen_q, changed_q;
	logic [PixelW-1:0]  value_q;
	logic [AddrW-1:0]   row_prod_q, col_prod_q, addr_q;
	logic [BankGW-1:0]  bankg_q, hi_units_q;
	logic [BankW-1:0]   bank_q;

	// divider
	logic [BankW-1:0] quo_q;
	logic [KbW-1:0]   rem_q;
	logic [KbW:0]     trial;
	logic             trial_ge;

	logic [AddrW-1:0]   row_prod, col_prod;
	logic [BankGW-1:0]  addr_units;
	logic               onscreen;
	logic [PixelW-1:0]  value;
	logic [OffsetW-1:0] near_offset;

	assign pb   = clamp_pb(pb_raw_q);
	assign gran = clamp_kb(gran_raw_q);
	assign win  = clamp_kb(win_raw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WidthRst;
			height_q   <= HeightRst;
			pitch_q    <= PitchRst;
			pb_raw_q   <= PbRst;
			layout_q   <= LayoutRst;
			gran_raw_q <= KbRst;
			win_raw_q  <= KbRst;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH:  width_q    <= cfg_data[ScreenW-1:0];
				REG_HEIGHT: height_q   <= cfg_data[ScreenW-1:0];
				REG_PITCH:  pitch_q    <= cfg_data[PitchW-1:0];
				REG_PBYTES: pb_raw_q   <= cfg_data[PbW-1:0];
				REG_LAYOUT: layout_q   <= cfg_data[LayoutW-1:0];
				REG_GRAN:   gran_raw_q <= cfg_data[KbW-1:0];
				REG_WINDOW: win_raw_q  <= cfg_data[KbW-1:0];
				default: ;
			endcase
		end
	end

	assign onscreen = !col_q[CoordW-1] && !row_q[CoordW-1]
		&& (col_q[ScreenW-1:0] < width_q) && (row_q[ScreenW-1:0] < height_q);

	assign value = place_colour(red_q, layout_q[18:15], layout_q[4:0])
		| place_colour(green_q, layout_q[22:19], layout_q[9:5])
		| place_colour(blue_q, layout_q[26:23], layout_q[14:10]);

	assign row_prod = AddrW'(row_q[ScreenW-1:0]) * AddrW'(pitch_q);
	assign col_prod = AddrW'(col_q[ScreenW-1:0]) * AddrW'(pb);

	// window bounds are whole KiB, so compare the address in KiB units
	assign addr_units = BankGW'(addr_q[AddrW-1:KbShift]);

	assign status.onscreen  = onscreen_q;
	assign status.in_window = (addr_units >= bankg_q) && (addr_units < hi_units_q);
	assign status.out_free  = !out_valid || !out_stall;

	assign trial    = {rem_q, quo_q[BankW-1]};
	assign trial_ge = trial >= {1'b0, gran};

	assign near_offset = addr_q[OffsetW-1:0] - {bankg_q[OffsetW-KbShift-1:0], {KbShift{1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q   <= column;
			row_q   <= row;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		if (cmd.mul) begin
			onscreen_q <= onscreen;
			value_q    <= value;
			row_prod_q <= row_prod;
			col_prod_q <= col_prod;
			bankg_q    <= BankGW'(bank_q) * BankGW'(gran);
		end
		if (cmd.addr) begin
			addr_q     <= row_prod_q + col_prod_q;
			hi_units_q <= bankg_q + BankGW'(win);
		end
		if (cmd.div_start) begin
			quo_q <= addr_q[AddrW-1:KbShift];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[BankW-2:0], trial_ge};
			rem_q <= trial_ge ? KbW'(trial - {1'b0, gran}) : trial[KbW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
			bank_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load)
				changed_q <= 1'b0;
			else if (cmd.div_start)
				changed_q <= 1'b1;
			if (cmd.commit) begin
				out_valid <= 1'b1;
				if (changed_q)
					bank_q <= quo_q;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			write_enable <= onscreen_q;
			bank_changed <= changed_q;
			bank_number  <= changed_q ? quo_q : bank_q;
			pixel_value  <= onscreen_q ? value_q : '0;
			byte_count   <= pb;
			if (!onscreen_q)
				window_offset <= '0;
			else if (changed_q)
				window_offset <= {rem_q[OffsetW-KbShift-1:0], addr_q[KbShift-1:0]};
			else
				window_offset <= near_offset;
		end
	end

endmodule

`default_nettype wire

@@ rtl/banked_framebuffer_pixel_writer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: a pixel is loaded, multiplied, addressed and checked; when the bank moves, a
// 16-step serial divide by the granularity follows; then the result is committed.
// Pixels are taken one at a time; a stalled, full output register holds up the commit.
// A finished result sits in the output register while the next pixel is taken.
// Reset (arst_n low, asynchronous): configuration registers return to their defaults, bank 0.

module banked_framebuffer_pixel_writer_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_write,
	input  wire  [bfpw_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire  [bfpw_pkg::CfgDataW-1:0]    cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [bfpw_pkg::CoordW-1:0]      column,
	input  wire  [bfpw_pkg::CoordW-1:0]      row,
	input  wire  [bfpw_pkg::ColourW-1:0]     red,
	input  wire  [bfpw_pkg::ColourW-1:0]     green,
	input  wire  [bfpw_pkg::ColourW-1:0]     blue,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             write_enable,
	output logic                             bank_changed,
	output logic [bfpw_pkg::BankW-1:0]       bank_number,
	output logic [bfpw_pkg::OffsetW-1:0]     window_offset,
	output logic [bfpw_pkg::PixelW-1:0]      pixel_value,
	output logic [bfpw_pkg::PbW-1:0]         byte_count
);
	import bfpw_pkg::*;

	cmd_t    cmd;
	status_t status;

	bfpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bfpw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.column        (column),
		.row           (row),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.write_enable  (write_enable),
		.bank_changed  (bank_changed),
		.bank_number   (bank_number),
		.window_offset (window_offset),
		.pixel_value   (pixel_value),
		.byte_count    (byte_count),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

`default_nettype wire

@@ rtl/bfpw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfpw_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire                           write_enable,
	input wire                           bank_changed,
	input wire [bfpw_pkg::BankW-1:0]     bank_number,
	input wire [bfpw_pkg::OffsetW-1:0]   window_offset,
	input wire [bfpw_pkg::PixelW-1:0]    pixel_value,
	input wire [bfpw_pkg::PbW-1:0]       byte_count
);
	import bfpw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(window_offset) && $stable(pixel_value)
			&& $stable(bank_number) && $stable(write_enable))
		else $error("stalled result changed");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> !bank_changed && pixel_value == '0
			&& window_offset == '0)
		else $error("dropped pixel carries data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count != '0 && byte_count <= PbMax)
		else $error("byte count out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second pixel taken while one is in flight");

endmodule

bind banked_framebuffer_pixel_writer_unit bfpw_checker u_bfpw_checker (.*);

`default_nettype wire

@@ tb/banked_framebuffer_pixel_writer_unit_tb.sv @@
`timescale 1ns / 1ps

module banked_framebuffer_pixel_writer_unit_tb;
	import bfpw_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int SettleCycles = 30;
	localparam int LongHold = 300;
	localparam int PhaseItems = 80;

	typedef struct packed {
		logic               we;
		logic               changed;
		logic [BankW-1:0]   bank;
		logic [OffsetW-1:0] offset;
		logic [PixelW-1:0]  value;
		logic [PbW-1:0]     count;
	} pixel_write_t;

	class pixel_write_tracker;
		logic [ScreenW-1:0] width_r;
		logic [ScreenW-1:0] height_r;
		logic [PitchW-1:0]  pitch_r;
		logic [PbW-1:0]     pbytes_r;
		logic [LayoutW-1:0] layout_r;
		logic [KbW-1:0]     gran_r;
		logic [KbW-1:0]     window_r;
		logic [BankW-1:0]   bank;
		pixel_write_t       expected_writes[$];
		int                 errors;

		function new();
			width_r = 12'd640;
			height_r = 12'd480;
			pitch_r = 14'd1280;
			pbytes_r = 3'd2;
			layout_r = '0;
			gran_r = 7'd64;
			window_r = 7'd64;
			bank = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_WIDTH: width_r = val[ScreenW-1:0];
				REG_HEIGHT: height_r = val[ScreenW-1:0];
				REG_PITCH: pitch_r = val[PitchW-1:0];
				REG_PBYTES: pbytes_r = val[PbW-1:0];
				REG_LAYOUT: layout_r = val;
				REG_GRAN: gran_r = val[KbW-1:0];
				REG_WINDOW: window_r = val[KbW-1:0];
				default: ;
			endcase
		endfunction

		// 0 acts as 1 KiB, anything past 64 as 64 KiB
		function longint kb_bytes(logic [KbW-1:0] kb);
			longint k;
			k = (kb == 0) ? 1 : ((kb > 64) ? 64 : longint'(kb));
			return k << KbShift;
		endfunction

		function logic [PixelW-1:0] fit_colour(logic [ColourW-1:0] c, logic [3:0] size,
				logic [4:0] pos);
			logic [PixelW-1:0] v;
			v = PixelW'(c);
			if (size < ColourW)
				v = v >> (ColourW - int'(size));
			return v << pos;
		endfunction

		function void predict_pixel(logic [CoordW-1:0] col, logic [CoordW-1:0] row,
				logic [ColourW-1:0] r, logic [ColourW-1:0] g, logic [ColourW-1:0] b);
			int c;
			int rw;
			int pb;
			longint gran;
			longint wsize;
			longint addr;
			longint low;
			pixel_write_t e;
			c = $signed(col);
			rw = $signed(row);
			pb = (pbytes_r == 0) ? 1 : ((pbytes_r > 4) ? 4 : int'(pbytes_r));
			e = '0;
			e.bank = bank;
			e.count = PbW'(pb);
			if (c < 0 || rw < 0 || c >= int'(width_r) || rw >= int'(height_r)) begin
				expected_writes.push_back(e);
				return;
			end
			gran = kb_bytes(gran_r);
			wsize = kb_bytes(window_r);
			addr = longint'(rw) * longint'(pitch_r) + longint'(c) * longint'(pb);
			low = longint'(bank) * gran;
			if (!(addr >= low && addr < low + wsize)) begin
				bank = BankW'(addr / gran);
				low = longint'(bank) * gran;
				e.changed = 1'b1;
			end
			e.we = 1'b1;
			e.bank = bank;
			e.offset = OffsetW'(addr - low);
			e.value = fit_colour(r, layout_r[18:15], layout_r[4:0])
				| fit_colour(g, layout_r[22:19], layout_r[9:5])
				| fit_colour(b, layout_r[26:23], layout_r[14:10]);
			expected_writes.push_back(e);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
		endtask

		task check_write(logic we, logic chg, logic [BankW-1:0] bnk, logic [OffsetW-1:0] off,
				logic [PixelW-1:0] val, logic [PbW-1:0] cnt);
			pixel_write_t e;
			if (expected_writes.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 0);
				return;
			end
			e = expected_writes.pop_front();
			if (we !== e.we) report_mismatch("write_enable", we, e.we);
			if (chg !== e.changed) report_mismatch("bank_changed", chg, e.changed);
			if (bnk !== e.bank) report_mismatch("bank_number", bnk, e.bank);
			if (off !== e.offset) report_mismatch("window_offset", off, e.offset);
			if (val !== e.value) report_mismatch("pixel_value", val, e.value);
			if (cnt !== e.count) report_mismatch("byte_count", cnt, e.count);
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_write;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [CoordW-1:0]   column;
	logic [CoordW-1:0]   row;
	logic [ColourW-1:0]  red;
	logic [ColourW-1:0]  green;
	logic [ColourW-1:0]  blue;
	logic                out_valid;
	logic                out_stall;
	logic                write_enable;
	logic                bank_changed;
	logic [BankW-1:0]    bank_number;
	logic [OffsetW-1:0]  window_offset;
	logic [PixelW-1:0]   pixel_value;
	logic [PbW-1:0]      byte_count;

	pixel_write_tracker tracker;
	bit steady = 1'b0;
	bit hold_out = 1'b0;
	int cycle_count = 0;

	banked_framebuffer_pixel_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.column(column),
		.row(row),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_enable(write_enable),
		.bank_changed(bank_changed),
		.bank_number(bank_number),
		.window_offset(window_offset),
		.pixel_value(pixel_value),
		.byte_count(byte_count)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_write(write_enable, bank_changed, bank_number, window_offset,
				pixel_value, byte_count);
	end

	// output side: random hold-off before each transaction unless steady, one long hold on request
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				n = LongHold;
			end else if (steady) begin
				n = 0;
			end else begin
				n = $urandom_range(0, 7);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [LayoutW-1:0] pack_layout(int rp, int gp, int bp, int rs, int gs,
			int bs);
		return {4'(bs), 4'(gs), 4'(rs), 5'(bp), 5'(gp), 5'(rp)};
	endfunction

	task write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
	endtask

	task load_config(int w, int h, int pitch, int pb, logic [LayoutW-1:0] lay, int g, int win);
		write_reg(REG_WIDTH, CfgDataW'(w));
		write_reg(REG_HEIGHT, CfgDataW'(h));
		write_reg(REG_PITCH, CfgDataW'(pitch));
		write_reg(REG_PBYTES, CfgDataW'(pb));
		write_reg(REG_LAYOUT, lay);
		write_reg(REG_GRAN, CfgDataW'(g));
		write_reg(REG_WINDOW, CfgDataW'(win));
		cfg_write <= 1'b0;
	endtask

	task send_pixel(logic [CoordW-1:0] c, logic [CoordW-1:0] r, logic [ColourW-1:0] rd,
			logic [ColourW-1:0] gr, logic [ColourW-1:0] bl);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		column <= c;
		row <= r;
		red <= rd;
		green <= gr;
		blue <= bl;
		do @(posedge clk); while (in_stall);
		tracker.predict_pixel(c, r, rd, gr, bl);
	endtask

	task send_random_pixel();
		int w;
		int h;
		logic [CoordW-1:0] c;
		logic [CoordW-1:0] r;
		w = int'(tracker.width_r);
		h = int'(tracker.height_r);
		c = CoordW'($urandom);
		r = CoordW'($urandom);
		case ($urandom_range(0, 9))
			0, 1: ;
			2: begin
				c = CoordW'(w + int'($urandom_range(0, 3)) - 2);
				r = CoordW'(h + int'($urandom_range(0, 3)) - 2);
			end
			3: begin
				if (w > 0) c = CoordW'(w - 1);
				if (h > 0) r = CoordW'($urandom_range(0, h - 1));
			end
			default: begin
				if (w > 0 && h > 0) begin
					c = CoordW'($urandom_range(0, w - 1));
					r = CoordW'($urandom_range(0, h - 1));
				end
			end
		endcase
		send_pixel(c, r, ColourW'($urandom), ColourW'($urandom), ColourW'($urandom));
	endtask

	task random_config();
		int w;
		int h;
		int pb;
		int pitch;
		int g;
		int win;
		logic [LayoutW-1:0] lay;
		case ($urandom_range(0, 4))
			0: w = $urandom_range(1, 40);
			1: w = $urandom_range(1, 4095);
			2: w = 4095;
			3: w = $urandom_range(0, 4095);
			default: w = $urandom_range(100, 800);
		endcase
		case ($urandom_range(0, 4))
			0: h = $urandom_range(1, 40);
			1: h = $urandom_range(1, 4095);
			2: h = 4095;
			3: h = $urandom_range(0, 4095);
			default: h = $urandom_range(100, 600);
		endcase
		pb = $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0: pitch = (w * ((pb == 0) ? 1 : ((pb > 4) ? 4 : pb))) & 16'h3fff;
			1: pitch = $urandom_range(0, 16383);
			2: pitch = 16383;
			default: pitch = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 3))
			0: lay = pack_layout(11, 5, 0, 5, 6, 5);
			1: lay = pack_layout(16, 8, 0, 8, 8, 8);
			default: lay = LayoutW'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: g = 64;
			1: g = 1;
			2: g = $urandom_range(1, 64);
			default: g = $urandom_range(0, 127);
		endcase
		case ($urandom_range(0, 3))
			0: win = 64;
			1: win = 1;
			2: win = $urandom_range(1, 64);
			default: win = $urandom_range(0, 127);
		endcase
		load_config(w, h, pitch, pb, lay, g, win);
	endtask

	// wait until every write has come back, then let the pipeline empty
	task settle();
		in_valid <= 1'b0;
		while (tracker.expected_writes.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		column <= '0;
		row <= '0;
		red <= '0;
		green <= '0;
		blue <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset; bottom-right corner forces a bank move and back
		send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(13'd639, 13'd479, 8'd0, 8'd0, 8'd0);
		send_pixel(13'd640, 13'd0, 8'd1, 8'd2, 8'd3);
		send_pixel(13'd0, 13'd480, 8'd1, 8'd2, 8'd3);
		send_pixel(13'(-1), 13'd5, 8'd9, 8'd9, 8'd9);
		send_pixel(13'd5, 13'(-1), 8'd9, 8'd9, 8'd9);
		send_pixel(13'(-4096), 13'(-4096), 8'd255, 8'd0, 8'd255);
		send_pixel(13'd4095, 13'd4095, 8'd0, 8'd255, 8'd0);
		send_pixel(13'd0, 13'd0, 8'd128, 8'd64, 8'd32);
		send_pixel(13'd1, 13'd0, 8'd127, 8'd63, 8'd31);
		settle();

		// largest screen and pitch, 565 packing
		load_config(4095, 4095, 16383, 4, pack_layout(11, 5, 0, 5, 6, 5), 64, 64);
		send_pixel(13'd4094, 13'd4094, 8'd255, 8'd0, 8'd128);
		send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255);
		settle();

		// zero pixel size, granularity and window act as one; fields near bit 31
		load_config(100, 100, 200, 0, pack_layout(31, 24, 16, 8, 15, 9), 0, 0);
		send_pixel(13'd99, 13'd99, 8'd255, 8'd255, 8'd255);
		send_pixel(13'd50, 13'd0, 8'd170, 8'd85, 8'd1);
		send_pixel(13'd0, 13'd1, 8'd170, 8'd85, 8'd1);
		settle();

		// zero width drops everything; oversize pixel, granularity and window clamp
		load_config(0, 50, 300, 7, pack_layout(0, 8, 16, 8, 8, 8), 127, 127);
		send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(13'd10, 13'd10, 8'd1, 8'd1, 8'd1);
		settle();

		// window smaller than granularity: pixel may land past the window end
		load_config(320, 200, 320, 1, pack_layout(16, 8, 0, 8, 8, 8), 64, 1);
		send_pixel(13'd319, 13'd199, 8'd255, 8'd128, 8'd1);
		send_pixel(13'd0, 13'd0, 8'd1, 8'd2, 8'd3);
		settle();

		// finest granularity
		load_config(640, 480, 1280, 2, pack_layout(0, 8, 16, 4, 0, 3), 1, 64);
		send_pixel(13'd639, 13'd479, 8'd240, 8'd15, 8'd224);
		send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(13'd320, 13'd240, 8'd16, 8'd32, 8'd64);
		settle();

		for (int p = 0; p < 8; p++) begin
			random_config();
			steady = (p == 2);
			if (p == 4)
				hold_out = 1'b1;
			for (int i = 0; i < PhaseItems; i++)
				send_random_pixel();
			settle();
		end
		steady = 1'b0;

		if (tracker.errors == 0 && tracker.expected_writes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bfpw_pkg.sv
rtl/bfpw_ctrl.sv
rtl/bfpw_datapath.sv
rtl/banked_framebuffer_pixel_writer_unit.sv
rtl/bfpw_checker.sv
tb/banked_framebuffer_pixel_writer_unit_tb.sv
